@@ rtl/core/tlig_pkg.sv @@
`default_nettype none

package tlig_pkg;

    localparam int unsigned IDX_W = 15;
    localparam int unsigned CRD_W = 8;
    localparam int unsigned ROW_W = 9;
    localparam int unsigned PRD_W = CRD_W + ROW_W;

    // configuration register indexes
    localparam logic [1:0] REG_PATCH_RES = 2'd0;
    localparam logic [1:0] REG_SRC_STEP  = 2'd1;
    localparam logic [1:0] REG_EDGE_MASK = 2'd2;

    localparam logic [7:0] RST_PATCH_RES = 8'd16;
    localparam logic [7:0] RST_SRC_STEP  = 8'd1;
    localparam logic [3:0] RST_EDGE_MASK = 4'd0;

    // edge mask bits
    localparam int unsigned EDGE_X0   = 0;
    localparam int unsigned EDGE_XMAX = 1;
    localparam int unsigned EDGE_Z0   = 2;
    localparam int unsigned EDGE_ZMAX = 3;

    // corner order: p00, p10, p01, p11
    localparam int unsigned P00 = 0;
    localparam int unsigned P10 = 1;
    localparam int unsigned P01 = 2;
    localparam int unsigned P11 = 3;

    typedef struct packed {
        logic [6:0] cell_x;
        logic [6:0] cell_z;
    } in_t;

    typedef struct packed {
        logic [IDX_W-1:0] index_a;
        logic [IDX_W-1:0] index_b;
        logic [IDX_W-1:0] index_c;
        logic             last_of_cell;
    } out_t;

    typedef struct packed {
        logic [7:0] patch_resolution;
        logic [7:0] source_step;
        logic [3:0] edge_mask;
    } cfg_t;

    // corner sample positions after snapping and stride scaling
    typedef struct packed {
        logic                  ok;
        logic                  parity;
        logic [ROW_W-1:0]      row;
        logic [3:0][CRD_W-1:0] xs;
        logic [3:0][CRD_W-1:0] zs;
    } setup_t;

    typedef struct packed {
        logic                  ok;
        logic                  parity;
        logic [3:0][IDX_W-1:0] idx;
    } corner_idx_t;

endpackage

`default_nettype wire

@@ rtl/core/terrain_lod_index_generator_top.sv @@
`default_nettype none

// Channel  Ports                          Payload
// input    s_valid, s_ready, s_data       tlig_pkg::in_t  (cell_x, cell_z)
// result   m_valid, m_ready, m_data       tlig_pkg::out_t (index_a..c, last_of_cell)
// config   cfg_valid, cfg_ready, cfg_addr, cfg_data (8 bits; edge mask uses low 4)
//
// A cell request passes input, setup/snap, multiply, add and triangle-select
// registers, then an output register that sends one triangle per cycle while
// m_ready is high. The output register sets the rate: a cell with two triangles
// holds it until both have left; a cell with none is dropped at triangle select.
// Reset (synchronous, active low) empties every stage and loads the register
// defaults. Stalls on m_ready hold every stage; bubbles are squeezed out.

module terrain_lod_index_generator_top #(
    parameter int unsigned MAX_RESOLUTION = 128
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire tlig_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output tlig_pkg::out_t      m_data,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [1:0]     cfg_addr,
    input  wire logic [7:0]     cfg_data
);

    tlig_pkg::cfg_t        cfg_reg;

    logic                  in_valid_reg;
    tlig_pkg::in_t         in_reg;
    logic                  setup_in_ready;

    logic                  setup_valid;
    logic                  index_in_ready;
    tlig_pkg::setup_t      setup_data;

    logic                  index_valid;
    logic                  emit_in_ready;
    tlig_pkg::corner_idx_t index_data;

    assign cfg_ready = 1'b1;
    assign s_ready   = !in_valid_reg || setup_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.patch_resolution <= tlig_pkg::RST_PATCH_RES;
            cfg_reg.source_step      <= tlig_pkg::RST_SRC_STEP;
            cfg_reg.edge_mask        <= tlig_pkg::RST_EDGE_MASK;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                tlig_pkg::REG_PATCH_RES: cfg_reg.patch_resolution <= cfg_data;
                tlig_pkg::REG_SRC_STEP:  cfg_reg.source_step      <= cfg_data;
                tlig_pkg::REG_EDGE_MASK: cfg_reg.edge_mask        <= cfg_data[3:0];
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    tlig_setup #(
        .MAX_RESOLUTION(MAX_RESOLUTION)
    ) u_setup (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (in_valid_reg),
        .in_ready (setup_in_ready),
        .in_cell  (in_reg),
        .out_valid(setup_valid),
        .out_ready(index_in_ready),
        .out_data (setup_data)
    );

    tlig_index u_index (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (setup_valid),
        .in_ready (index_in_ready),
        .in_data  (setup_data),
        .out_valid(index_valid),
        .out_ready(emit_in_ready),
        .out_data (index_data)
    );

    tlig_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (index_valid),
        .in_ready (emit_in_ready),
        .in_data  (index_data),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_data (m_data)
    );

endmodule

`default_nettype wire

@@ rtl/core/tlig_setup.sv @@
`default_nettype none

module tlig_setup #(
    parameter int unsigned MAX_RESOLUTION = 128
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire tlig_pkg::cfg_t cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire tlig_pkg::in_t  in_cell,
    output logic                out_valid,
    input  wire logic           out_ready,
    output tlig_pkg::setup_t    out_data
);

    typedef struct packed {
        logic [tlig_pkg::CRD_W-1:0] lx;
        logic [tlig_pkg::CRD_W-1:0] lz;
    } crd_t;

    function automatic crd_t snap_corner(input logic [7:0] lx_in, input logic [7:0] lz_in,
                                         input logic [7:0] cells, input logic [3:0] mask);
        crd_t c;
        c.lx = lx_in;
        c.lz = lz_in;
        if (mask[tlig_pkg::EDGE_X0] && c.lx == 8'd0 && c.lz[0]) begin
            c.lz = c.lz - 8'd1;
        end
        if (mask[tlig_pkg::EDGE_XMAX] && c.lx == cells && c.lz[0]) begin
            c.lz = c.lz - 8'd1;
        end
        if (mask[tlig_pkg::EDGE_Z0] && c.lz == 8'd0 && c.lx[0]) begin
            c.lx = c.lx - 8'd1;
        end
        if (mask[tlig_pkg::EDGE_ZMAX] && c.lz == cells && c.lx[0]) begin
            c.lx = c.lx - 8'd1;
        end
        return c;
    endfunction

    logic [2:0]       shift;
    logic [7:0]       cells;
    logic             cfg_ok;
    logic             grid_ok;
    logic [7:0]       cx;
    logic [7:0]       cz;
    logic [3:0][7:0]  lx_raw;
    logic [3:0][7:0]  lz_raw;
    crd_t [3:0]       snapped;

    logic             valid_reg;
    tlig_pkg::setup_t data_reg;
    tlig_pkg::setup_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        shift = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (cfg.source_step[i]) begin
                shift = 3'(i);
            end
        end
    end

    assign cells = cfg.patch_resolution >> shift;

    assign cfg_ok = (cfg.patch_resolution != 8'd0)
                 && ({1'b0, cfg.patch_resolution} <= 9'(MAX_RESOLUTION))
                 && (cfg.source_step != 8'd0)
                 && ((cfg.source_step & (cfg.source_step - 8'd1)) == 8'd0)
                 && ((cfg.patch_resolution & (cfg.source_step - 8'd1)) == 8'd0)
                 && ((cfg.edge_mask == 4'd0) || (cells >= 8'd2 && !cells[0]));

    assign cx      = {1'b0, in_cell.cell_x};
    assign cz      = {1'b0, in_cell.cell_z};
    assign grid_ok = (cx < cells) && (cz < cells);

    assign lx_raw[tlig_pkg::P00] = cx;
    assign lz_raw[tlig_pkg::P00] = cz;
    assign lx_raw[tlig_pkg::P10] = cx + 8'd1;
    assign lz_raw[tlig_pkg::P10] = cz;
    assign lx_raw[tlig_pkg::P01] = cx;
    assign lz_raw[tlig_pkg::P01] = cz + 8'd1;
    assign lx_raw[tlig_pkg::P11] = cx + 8'd1;
    assign lz_raw[tlig_pkg::P11] = cz + 8'd1;

    always_comb begin
        data_next.ok     = cfg_ok && grid_ok;
        data_next.parity = cx[0] ^ cz[0];
        data_next.row    = {1'b0, cfg.patch_resolution} + 9'd1;
        for (int k = 0; k < 4; k++) begin
            snapped[k]      = snap_corner(lx_raw[k], lz_raw[k], cells, cfg.edge_mask);
            data_next.xs[k] = snapped[k].lx << shift;
            data_next.zs[k] = snapped[k].lz << shift;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tlig_index.sv @@
`default_nettype none

module tlig_index (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire tlig_pkg::setup_t      in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output tlig_pkg::corner_idx_t      out_data
);

    // multiply stage
    logic                                     mul_valid_reg;
    logic                                     mul_ready;
    logic                                     mul_ok_reg;
    logic                                     mul_par_reg;
    logic [3:0][tlig_pkg::PRD_W-1:0]          prod_reg;
    logic [3:0][tlig_pkg::PRD_W-1:0]          prod_next;
    logic [3:0][tlig_pkg::CRD_W-1:0]          xs_reg;

    // add stage
    logic                                     add_valid_reg;
    tlig_pkg::corner_idx_t                    add_reg;
    tlig_pkg::corner_idx_t                    add_next;

    assign mul_ready = !add_valid_reg || out_ready;
    assign in_ready  = !mul_valid_reg || mul_ready;
    assign out_valid = add_valid_reg;
    assign out_data  = add_reg;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            prod_next[k] = tlig_pkg::PRD_W'(in_data.zs[k]) * tlig_pkg::PRD_W'(in_data.row);
        end
    end

    always_comb begin
        add_next.ok     = mul_ok_reg;
        add_next.parity = mul_par_reg;
        for (int k = 0; k < 4; k++) begin
            add_next.idx[k] = tlig_pkg::IDX_W'(prod_reg[k] + tlig_pkg::PRD_W'(xs_reg[k]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            add_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                mul_valid_reg <= in_valid;
            end
            if (mul_ready) begin
                add_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            prod_reg    <= prod_next;
            xs_reg      <= in_data.xs;
            mul_ok_reg  <= in_data.ok;
            mul_par_reg <= in_data.parity;
        end
        if (mul_ready && mul_valid_reg) begin
            add_reg <= add_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tlig_emit.sv @@
`default_nettype none

module tlig_emit (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire tlig_pkg::corner_idx_t in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output tlig_pkg::out_t             out_data
);

    typedef struct packed {
        logic [tlig_pkg::IDX_W-1:0] a;
        logic [tlig_pkg::IDX_W-1:0] b;
        logic [tlig_pkg::IDX_W-1:0] c;
    } tri_t;

    function automatic logic tri_live(input tri_t t);
        return (t.a != t.b) && (t.a != t.c) && (t.b != t.c);
    endfunction

    // triangle select stage
    logic        sel_valid_reg;
    logic        sel_ready;
    tri_t        tri0_next;
    tri_t        tri1_next;
    logic        keep0_next;
    logic        keep1_next;
    tri_t        sel_tri0_reg;
    tri_t        sel_tri1_reg;
    logic        sel_keep0_reg;
    logic        sel_keep1_reg;

    // output stage, holds up to two triangles of a cell and shows one at a time
    logic        pend0_reg;
    logic        pend1_reg;
    tri_t        out_tri0_reg;
    tri_t        out_tri1_reg;
    logic        out_free;
    tri_t        shown;

    always_comb begin
        if (!in_data.parity) begin
            tri0_next = '{a: in_data.idx[tlig_pkg::P00], b: in_data.idx[tlig_pkg::P01],
                          c: in_data.idx[tlig_pkg::P11]};
            tri1_next = '{a: in_data.idx[tlig_pkg::P00], b: in_data.idx[tlig_pkg::P11],
                          c: in_data.idx[tlig_pkg::P10]};
        end else begin
            tri0_next = '{a: in_data.idx[tlig_pkg::P01], b: in_data.idx[tlig_pkg::P11],
                          c: in_data.idx[tlig_pkg::P10]};
            tri1_next = '{a: in_data.idx[tlig_pkg::P00], b: in_data.idx[tlig_pkg::P01],
                          c: in_data.idx[tlig_pkg::P10]};
        end
        keep0_next = in_data.ok && tri_live(tri0_next);
        keep1_next = in_data.ok && tri_live(tri1_next);
    end

    // free when empty or when the last pending triangle leaves this cycle
    assign out_free  = !(pend0_reg || pend1_reg) || (out_ready && (pend0_reg ^ pend1_reg));
    assign sel_ready = !sel_valid_reg || out_free;
    assign in_ready  = sel_ready;

    assign out_valid = pend0_reg || pend1_reg;
    assign shown     = pend0_reg ? out_tri0_reg : out_tri1_reg;
    assign out_data  = '{index_a: shown.a, index_b: shown.b, index_c: shown.c,
                         last_of_cell: !(pend0_reg && pend1_reg)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_valid_reg <= 1'b0;
            pend0_reg     <= 1'b0;
            pend1_reg     <= 1'b0;
        end else begin
            // drop cells that produce no triangle here
            if (sel_ready) begin
                sel_valid_reg <= in_valid && (keep0_next || keep1_next);
            end
            if (out_free && sel_valid_reg) begin
                pend0_reg <= sel_keep0_reg;
                pend1_reg <= sel_keep1_reg;
            end else if (out_valid && out_ready) begin
                if (pend0_reg) begin
                    pend0_reg <= 1'b0;
                end else begin
                    pend1_reg <= 1'b0;
                end
            end else if (out_free) begin
                pend0_reg <= 1'b0;
                pend1_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sel_ready && in_valid) begin
            sel_tri0_reg  <= tri0_next;
            sel_tri1_reg  <= tri1_next;
            sel_keep0_reg <= keep0_next;
            sel_keep1_reg <= keep1_next;
        end
        if (out_free && sel_valid_reg) begin
            out_tri0_reg <= sel_tri0_reg;
            out_tri1_reg <= sel_tri1_reg;
        end
    end

endmodule

`default_nettype wire
